FILE: rtl/stsi_pkg.sv
// Shared types, constants and helpers for the string-to-integer parser.
`default_nettype none

package stsi_pkg;

    localparam int unsigned RADIX_W = 6;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned PROD_W  = VALUE_W + RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_NONE    = 6'd63;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_BASE = 2'd2;

    localparam logic [VALUE_W-1:0] SIGNED_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] SIGNED_MIN_MAG = 64'h8000_0000_0000_0000;

    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_D0    = 8'd48;
    localparam logic [CH_W-1:0] CH_D9    = 8'd57;
    localparam logic [CH_W-1:0] CH_UA    = 8'd65;
    localparam logic [CH_W-1:0] CH_UZ    = 8'd90;
    localparam logic [CH_W-1:0] CH_LA    = 8'd97;
    localparam logic [CH_W-1:0] CH_LZ    = 8'd122;
    localparam logic [CH_W-1:0] LETTER_BASE = 8'd10;

    typedef enum logic [1:0] {
        PH_DONE,
        PH_LEAD,
        PH_DIGITS
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } stsi_cmd_t;

    typedef struct packed {
        logic has_result;
    } stsi_stat_t;

    function automatic logic [RADIX_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [RADIX_W-1:0] v;
        v = DIGIT_NONE;
        if (c >= CH_D0 && c <= CH_D9) begin
            v = RADIX_W'(c - CH_D0);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            v = RADIX_W'(c - CH_UA + LETTER_BASE);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            v = RADIX_W'(c - CH_LA + LETTER_BASE);
        end
        return v;
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/string_to_signed_integer_parser.sv
// Top level of the streaming string-to-signed-integer parser.
//
// Usage:
//   Input channel (s_valid/s_ready, s_ch, s_new_string) carries one character
//   per transfer; s_new_string marks the first character of a string and
//   restarts the parse with the base held in the radix register.
//   Result channel (m_valid/m_ready) carries the signed value, a status
//   (ok, out of range, invalid base) and the end position, at most one
//   result per string.
//   Configuration: cfg_wr_en writes cfg_wr_data into the radix register;
//   the value takes effect at the next new string.
//   Timing: each character is first captured and then updates the parse
//   state; the block takes no new character until that update is done. The
//   capture step lets the magnitude-times-base multiplier, which is
//   registered before the add and limit compare, settle. A result appears on
//   m_valid on the cycle after its character's update cycle.
//   Stall: the result register holds until taken; characters that give no
//   result keep flowing meanwhile, and a character that gives a result
//   waits in its update cycle until the result register is free.
//   Reset (aresetn low, synchronous): radix returns to 10, no string is
//   active, and no result is pending.
`default_nettype none

module string_to_signed_integer_parser import stsi_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [RADIX_W-1:0]   cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CH_W-1:0]      s_ch,
    input  wire logic                 s_new_string,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [VALUE_W-1:0] m_result_value,
    output logic [STAT_W-1:0]         m_status,
    output logic [POS_W-1:0]          m_end_position
);

    stsi_cmd_t  cmd;
    stsi_stat_t stat;

    // sequence capture and update, hold results for the receiver
    stsi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // parse state, arithmetic and result register
    stsi_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_ch           (s_ch),
        .s_new_string   (s_new_string),
        .cmd            (cmd),
        .stat           (stat),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_end_position (m_end_position)
    );

endmodule

`default_nettype wire

FILE: rtl/stsi_ctrl.sv
// Handshake controller: sequences accept and execute, owns the result valid flag.
`default_nettype none

module stsi_ctrl import stsi_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire stsi_stat_t stat,
    output stsi_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!stat.has_result || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = !stat.has_result || out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec && stat.has_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stsi_datapath.sv
// Parse datapath: radix register, parse state, base multiply, overflow check, result register.
`default_nettype none

module stsi_datapath import stsi_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [RADIX_W-1:0]  cfg_wr_data,
    input  wire logic [CH_W-1:0]     s_ch,
    input  wire logic                s_new_string,
    input  wire stsi_cmd_t           cmd,
    output stsi_stat_t               stat,
    output logic signed [VALUE_W-1:0] m_result_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [POS_W-1:0]         m_end_position
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic [CH_W-1:0]    ch_reg;
    logic               ns_reg;
    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic               any_reg, any_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PROD_W-1:0]  prod_reg;

    logic [VALUE_W-1:0] res_value_reg, res_value;
    logic [STAT_W-1:0]  res_status_reg, res_status;
    logic [POS_W-1:0]   res_end_reg, res_end;

    logic [RADIX_W-1:0] base_new, base_eff, dval;
    logic               bad_base, neg_eff, any_eff;
    phase_t             ph_eff;
    logic [VALUE_W-1:0] mag_eff;
    logic [POS_W-1:0]   pos_eff, pos_inc;
    logic [PROD_W-1:0]  prod_eff;
    logic [PROD_W:0]    sum, lim;

    always_comb begin
        base_new = (radix_reg == '0) ? RADIX_DEFAULT : radix_reg;
        bad_base = ns_reg && (base_new < RADIX_MIN || base_new > RADIX_MAX);
        // a new string restarts from a cleared state
        base_eff = ns_reg ? base_new : base_reg;
        ph_eff   = ns_reg ? PH_LEAD : phase_reg;
        neg_eff  = ns_reg ? 1'b0 : neg_reg;
        any_eff  = ns_reg ? 1'b0 : any_reg;
        mag_eff  = ns_reg ? '0 : mag_reg;
        pos_eff  = ns_reg ? '0 : pos_reg;
        prod_eff = ns_reg ? '0 : prod_reg;
        pos_inc  = (pos_eff == '1) ? pos_eff : pos_eff + POS_W'(1);
        dval     = digit_value(ch_reg);
        sum      = {1'b0, prod_eff} + (PROD_W + 1)'(dval);
        lim      = neg_eff ? (PROD_W + 1)'(SIGNED_MIN_MAG) : (PROD_W + 1)'(SIGNED_MAX);

        base_next  = bad_base ? base_reg : base_eff;
        phase_next = ph_eff;
        neg_next   = neg_eff;
        any_next   = any_eff;
        mag_next   = mag_eff;
        pos_next   = pos_eff;
        stat.has_result = 1'b0;
        res_value  = '0;
        res_status = STATUS_OK;
        res_end    = '0;

        priority if (bad_base) begin
            stat.has_result = 1'b1;
            res_status      = STATUS_BAD_BASE;
            phase_next      = PH_DONE;
        end else if (ph_eff == PH_DONE) begin
            phase_next = PH_DONE;
        end else if (ph_eff == PH_LEAD && is_space(ch_reg)) begin
            pos_next = pos_inc;
        end else if (ph_eff == PH_LEAD && (ch_reg == CH_MINUS || ch_reg == CH_PLUS)) begin
            phase_next = PH_DIGITS;
            neg_next   = (ch_reg == CH_MINUS);
            pos_next   = pos_inc;
        end else begin
            phase_next = PH_DIGITS;
            if (dval < base_eff) begin
                if (sum > lim) begin
                    // saturate and stop at the overflowing digit
                    stat.has_result = 1'b1;
                    res_value       = neg_eff ? SIGNED_MIN_MAG : SIGNED_MAX;
                    res_status      = STATUS_RANGE;
                    res_end         = pos_eff;
                    phase_next      = PH_DONE;
                end else begin
                    mag_next = sum[VALUE_W-1:0];
                    any_next = 1'b1;
                    pos_next = pos_inc;
                end
            end else begin
                stat.has_result = 1'b1;
                phase_next      = PH_DONE;
                if (any_eff) begin
                    res_value = neg_eff ? (VALUE_W'(0) - mag_eff) : mag_eff;
                    res_end   = pos_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_DEFAULT;
            base_reg  <= RADIX_DEFAULT;
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            any_reg   <= 1'b0;
            mag_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                radix_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                base_reg  <= base_next;
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                any_reg   <= any_next;
                mag_reg   <= mag_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg <= s_ch;
            ns_reg <= s_new_string;
        end
        // magnitude times base, registered from the magnitude and base registers
        prod_reg <= {{RADIX_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, base_reg};
        if (cmd.exec && stat.has_result) begin
            res_value_reg  <= res_value;
            res_status_reg <= res_status;
            res_end_reg    <= res_end;
        end
    end

    assign m_result_value = res_value_reg;
    assign m_status       = res_status_reg;
    assign m_end_position = res_end_reg;

endmodule

`default_nettype wire

FILE: rtl/stsi_checker.sv
// Port-level checker for the parser, bound to the top level.
`default_nettype none

module stsi_checker import stsi_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 cfg_wr_en,
    input wire logic [RADIX_W-1:0]   cfg_wr_data,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic [CH_W-1:0]      s_ch,
    input wire logic                 s_new_string,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [VALUE_W-1:0]   m_result_value,
    input wire logic [STAT_W-1:0]    m_status,
    input wire logic [POS_W-1:0]     m_end_position
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_status) && $stable(m_end_position))
        else $error("stalled result changed");

    // s_ready falls after each accepted character
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transfer accepted on back-to-back cycles");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_RANGE
            || m_status == STATUS_BAD_BASE))
        else $error("undefined status code");

    a_bad_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_BAD_BASE |->
            m_result_value == '0 && m_end_position == '0)
        else $error("invalid base result not zero");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_RANGE |->
            (m_result_value == SIGNED_MAX || m_result_value == SIGNED_MIN_MAG))
        else $error("range result not saturated");

endmodule

bind string_to_signed_integer_parser stsi_checker u_stsi_checker (.*);

`default_nettype wire

FILE: tb/stsi_result_checker.sv
// Result checker for the string-to-integer parser: tracks the parse and compares results.
module stsi_result_checker import stsi_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [RADIX_W-1:0]   cfg_wr_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [CH_W-1:0]      s_ch,
    input  wire logic                 s_new_string,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [VALUE_W-1:0]   m_result_value,
    input  wire logic [STAT_W-1:0]    m_status,
    input  wire logic [POS_W-1:0]     m_end_position,
    output int unsigned               fail_count,
    output int unsigned               pending_count
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   end_pos;
    } parse_result_t;

    parse_result_t      expected_results[$];
    int unsigned        mismatches;

    logic [RADIX_W-1:0] radix_q;
    logic [RADIX_W-1:0] base_q;
    phase_t             parse_phase;
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
    logic [POS_W-1:0]   position;
    logic               got_digit;

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        case (c)
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Digit weight of a character, 99 when it is no digit in any base.
    function automatic int unsigned char_weight(input logic [CH_W-1:0] c);
        int unsigned w;
        w = 99;
        if (c >= CH_D0 && c <= CH_D9) begin
            w = 32'(c - CH_D0);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            w = 32'(c - CH_UA) + 10;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            w = 32'(c - CH_LA) + 10;
        end
        return w;
    endfunction

    function automatic void bump_position();
        if (position != {POS_W{1'b1}}) begin
            position = position + POS_W'(1);
        end
    endfunction

    task automatic predict_parse(input logic [CH_W-1:0] c, input logic ns,
                                 output bit fire, output parse_result_t res);
        logic [RADIX_W-1:0] b;
        int unsigned        w;
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] quo;
        logic [VALUE_W-1:0] rem;
        fire = 1'b0;
        res  = '0;
        if (ns) begin
            b         = (radix_q == '0) ? RADIX_DEFAULT : radix_q;
            position  = '0;
            magnitude = '0;
            negative  = 1'b0;
            got_digit = 1'b0;
            if (b < RADIX_MIN || b > RADIX_MAX) begin
                fire        = 1'b1;
                res.status  = STATUS_BAD_BASE;
                parse_phase = PH_DONE;
                return;
            end
            base_q      = b;
            parse_phase = PH_LEAD;
        end
        if (parse_phase == PH_DONE) begin
            return;
        end
        if (parse_phase == PH_LEAD) begin
            if (is_blank(c)) begin
                bump_position();
                return;
            end
            parse_phase = PH_DIGITS;
            if (c == CH_MINUS || c == CH_PLUS) begin
                negative = (c == CH_MINUS);
                bump_position();
                return;
            end
        end
        w = char_weight(c);
        if (w < base_q) begin
            lim = negative ? SIGNED_MIN_MAG : SIGNED_MAX;
            quo = lim / VALUE_W'(base_q);
            rem = lim % VALUE_W'(base_q);
            if (magnitude > quo || (magnitude == quo && VALUE_W'(w) > rem)) begin
                fire        = 1'b1;
                res.value   = lim;
                res.status  = STATUS_RANGE;
                res.end_pos = position;
                parse_phase = PH_DONE;
                return;
            end
            magnitude = magnitude * VALUE_W'(base_q) + VALUE_W'(w);
            got_digit = 1'b1;
            bump_position();
            return;
        end
        fire        = 1'b1;
        parse_phase = PH_DONE;
        res.status  = STATUS_OK;
        if (got_digit) begin
            res.value   = negative ? -magnitude : magnitude;
            res.end_pos = position;
        end
    endtask

    always @(posedge aclk) begin : watch
        parse_result_t got;
        parse_result_t want;
        parse_result_t fresh;
        bit            fire;
        if (!aresetn) begin
            expected_results.delete();
            radix_q     = RADIX_DEFAULT;
            base_q      = RADIX_DEFAULT;
            parse_phase = PH_DONE;
            negative    = 1'b0;
            magnitude   = '0;
            position    = '0;
            got_digit   = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.value   = m_result_value;
                got.status  = m_status;
                got.end_pos = m_end_position;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d end %0d",
                             $time, $signed(got.value), got.status, got.end_pos);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: value expected %0d actual %0d", $time,
                                 $signed(want.value), $signed(got.value));
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        mismatches++;
                    end
                    if (got.end_pos !== want.end_pos) begin
                        $display("%0t: end position expected %0d actual %0d", $time,
                                 want.end_pos, got.end_pos);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_parse(s_ch, s_new_string, fire, fresh);
                if (fire) begin
                    expected_results.push_back(fresh);
                end
            end
            if (cfg_wr_en) begin
                radix_q = cfg_wr_data;
            end
        end
        pending_count <= expected_results.size();
        fail_count    <= mismatches;
    end

endmodule

FILE: tb/tb_string_to_signed_integer_parser.sv
// Testbench top for the string-to-integer parser: stimulus, receiver stalls and verdict.
module tb_string_to_signed_integer_parser;
    import stsi_pkg::*;

    localparam int unsigned ITEM_TARGET     = 1350;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_PHASE  = 3;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_EAGER
    } rx_mode_e;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [RADIX_W-1:0]   cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CH_W-1:0]      s_ch;
    logic                 s_new_string;
    logic                 m_valid;
    logic                 m_ready;
    logic [VALUE_W-1:0]   m_result_value;
    logic [STAT_W-1:0]    m_status;
    logic [POS_W-1:0]     m_end_position;

    int unsigned          fail_count;
    int unsigned          pending_count;
    int unsigned          cycle_count;
    int unsigned          items_sent;
    int unsigned          burst_left;
    bit                   hold_off_req;
    logic [CH_W-1:0]      line_buf[$];

    always #5 aclk = ~aclk;

    string_to_signed_integer_parser DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_new_string   (s_new_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_end_position (m_end_position)
    );

    stsi_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_new_string   (s_new_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_end_position (m_end_position),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // Watchdog: end the run if it hangs anywhere.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall according to a randomly drawn mode that is redrawn when its
    // run ends, and take one long hold-off when the stimulus asks for it, so the result register
    // stays full and the parser has to stall its input.
    initial begin : receiver
        rx_mode_e    mode;
        int unsigned mode_left;
        bit          hold_off_taken;
        m_ready        = 1'b0;
        mode           = RX_FREE;
        mode_left      = 0;
        hold_off_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    // Offer one character and hold it until the transfer. The sender runs in
    // bursts; between bursts drop valid for a random gap.
    task automatic send_item(input logic [CH_W-1:0] c, input logic ns, input bit counted);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
        end
        s_valid      <= 1'b1;
        s_ch         <= c;
        s_new_string <= ns;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (counted) begin
            items_sent++;
        end
    endtask

    // Send the line buffer as one string; optionally follow it with junk
    // that carries no new-string flag.
    task automatic send_line(input bit allow_junk);
        foreach (line_buf[i]) begin
            send_item(line_buf[i], (i == 0), 1'b1);
        end
        if (allow_junk && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_item(CH_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
        end
    endtask

    // Pause the sender until every expected result is in, then let the
    // parser finish any character still in flight.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic load_text(input string t);
        line_buf.delete();
        for (int i = 0; i < t.len(); i++) begin
            line_buf.push_back(t[i]);
        end
    endtask

    function automatic logic [CH_W-1:0] digit_char(input int unsigned d);
        if (d < 10) begin
            return CH_D0 + CH_W'(d);
        end
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CH_W'(d - 10);
    endfunction

    task automatic push_blank();
        int unsigned k;
        k = $urandom_range(0, 5);
        line_buf.push_back((k == 5) ? CH_SPACE : CH_TAB + CH_W'(k));
    endtask

    // Append the base-b digits of v, most significant first.
    task automatic push_number(input logic [VALUE_W-1:0] v, input int unsigned b);
        logic [CH_W-1:0] digs[0:VALUE_W-1];
        int              n;
        n = 0;
        if (v == '0) begin
            digs[0] = CH_D0;
            n = 1;
        end
        while (v != '0) begin
            digs[n] = digit_char(32'(v % b));
            v = v / b;
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            line_buf.push_back(digs[i]);
        end
    endtask

    task automatic push_end();
        case ($urandom_range(0, 3))
            0: line_buf.push_back(8'd0);
            1: line_buf.push_back(CH_W'($urandom_range(0, 255)));
            2: line_buf.push_back(CH_SPACE);
            default: ;  // no terminator: the next string cuts this one off
        endcase
    endtask

    // Number with random content: blanks, optional sign, base-b digits (possibly none).
    task automatic build_plain(input int unsigned b);
        int unsigned n;
        line_buf.delete();
        repeat ($urandom_range(0, 3)) push_blank();
        case ($urandom_range(0, 2))
            1: line_buf.push_back(CH_PLUS);
            2: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 8);
        repeat (n) line_buf.push_back(digit_char($urandom_range(0, b - 1)));
        push_end();
    endtask

    // Number close to the signed limit in either direction, near the limit divided by the base, or huge.
    task automatic build_edge(input int unsigned b);
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] v;
        bit                 neg;
        line_buf.delete();
        if ($urandom_range(0, 1)) push_blank();
        neg = $urandom_range(0, 1);
        if (neg) begin
            line_buf.push_back(CH_MINUS);
        end else if ($urandom_range(0, 1)) begin
            line_buf.push_back(CH_PLUS);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(CH_D0);
        end
        lim = neg ? SIGNED_MIN_MAG : SIGNED_MAX;
        case ($urandom_range(0, 4))
            0: v = lim;
            1: v = lim - $urandom_range(1, 2 * b);
            2: v = lim + $urandom_range(1, 2 * b);
            3: v = lim / b;
            default: v = {$urandom, $urandom};
        endcase
        push_number(v, b);
        if ($urandom_range(0, 3) == 0) begin
            line_buf.push_back(digit_char($urandom_range(0, b - 1)));
        end
        line_buf.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
    endtask

    // Scrambled mix of blanks, signs, digits, letters and terminators.
    task automatic build_broken(input int unsigned b);
        line_buf.delete();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 6))
                0: push_blank();
                1: line_buf.push_back(CH_PLUS);
                2: line_buf.push_back(CH_MINUS);
                3: line_buf.push_back(digit_char($urandom_range(0, b - 1)));
                4: line_buf.push_back(digit_char($urandom_range(10, 35)));
                5: line_buf.push_back(8'd0);
                default: line_buf.push_back(CH_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic build_noise();
        line_buf.delete();
        repeat ($urandom_range(1, 6)) line_buf.push_back(CH_W'($urandom_range(0, 255)));
    endtask

    task automatic build_random_line(input int unsigned b);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            build_plain(b);
        end else if (r < 75) begin
            build_edge(b);
        end else if (r < 88) begin
            build_broken(b);
        end else begin
            build_noise();
        end
    endtask

    // Fixed bases for the first phases (extremes and invalid ones), then random.
    function automatic logic [RADIX_W-1:0] pick_radix(input int unsigned idx);
        case (idx)
            0: return 6'd36;
            1: return 6'd2;
            2: return 6'd0;
            3: return 6'd10;
            4: return 6'd1;
            5: return 6'd16;
            6: return 6'd37;
            7: return 6'd63;
            8: return 6'd35;
            9: return 6'd3;
            default: begin
                case ($urandom_range(0, 9))
                    0: return 6'd0;
                    1: return $urandom_range(0, 1) ? 6'd1 : 6'($urandom_range(37, 63));
                    default: return RADIX_W'($urandom_range(2, 36));
                endcase
            end
        endcase
    endfunction

    initial begin : stimulus
        int unsigned        phase_idx;
        int unsigned        phase_end;
        int unsigned        base_eff;
        logic [RADIX_W-1:0] radix_pick;
        bit                 base_ok;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_ch         = '0;
        s_new_string = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, base 10 from reset first.
        send_item(CH_D0 + 8'd5, 1'b0, 1'b1);  // before any string: ignored
        load_text("");                        // lone terminator: no digits
        line_buf.push_back(8'd0);
        send_line(1'b0);
        load_text("-x");                      // sign with no digits after it
        send_line(1'b0);
        load_text(" \t+7z");                  // blanks, plus sign, letter ends it
        send_line(1'b0);
        send_item("q", 1'b0, 1'b1);           // after the result: ignored
        load_text("12");                      // cut off by the next string
        send_line(1'b0);
        load_text("3");
        line_buf.push_back(8'd0);
        send_line(1'b0);
        drain();
        write_radix(6'd1);                    // invalid base
        load_text("a");
        send_line(1'b0);
        drain();
        write_radix(6'd0);                    // zero stands for ten
        load_text("9,");
        send_line(1'b0);
        drain();
        write_radix(6'd63);                   // top of the register: invalid
        load_text("7");
        send_line(1'b0);
        drain();
        write_radix(RADIX_MAX);               // both letter cases in base 36
        load_text("zZ");
        line_buf.push_back(8'd0);
        send_line(1'b0);
        drain();
        write_radix(RADIX_MIN);               // digit 2 ends a binary number
        load_text("12");
        send_line(1'b0);

        // Random phases, one base each, written while the parser is idle.
        phase_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            drain();
            radix_pick = pick_radix(phase_idx);
            write_radix(radix_pick);
            base_eff = (radix_pick == '0) ? 10 : radix_pick;
            base_ok  = (base_eff >= RADIX_MIN && base_eff <= RADIX_MAX);
            if (!base_ok) begin
                base_eff = 10;
            end
            if (phase_idx == HOLD_OFF_PHASE) begin
                hold_off_req = 1'b1;
            end
            phase_end = items_sent + (base_ok ? 160 : 40);
            while (items_sent < phase_end) begin
                build_random_line(base_eff);
                send_line(1'b1);
            end
            phase_idx++;
        end

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
